/* src/dch_pkg.sv */
// Shared constants and controller/datapath interface types for the distinct color histogram.
// No dependencies; every other file of the block imports this package.
package dch_pkg;

  localparam int unsigned TableEntriesDefault = 64;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CountW = 16;
  localparam int unsigned EntryNumW = 6;
  localparam int unsigned InDataW = 32;
  localparam int unsigned OutDataW = 72;

  typedef struct packed {
    logic capture;
    logic update;
    logic shift;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic final_entry;
  } status_t;

endpackage

/* src/dch_lane.sv */
// One table entry of the histogram: stored color, saturating count and match flag.
// Depends on dch_pkg.
module dch_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic                      capture_i,
  input  logic                      inc_i,
  input  logic                      write_i,
  input  logic                      shift_i,
  input  logic [dch_pkg::ColorW-1:0] pix_i,
  input  logic [dch_pkg::ColorW-1:0] wr_color_i,
  input  logic [dch_pkg::ColorW-1:0] next_color_i,
  input  logic [dch_pkg::CountW-1:0] next_count_i,
  output logic [dch_pkg::ColorW-1:0] color_o,
  output logic [dch_pkg::CountW-1:0] count_o,
  output logic                      match_o
);
  import dch_pkg::*;

  logic [ColorW-1:0] color_q, color_d;
  logic [CountW-1:0] count_q, count_d;
  logic              match_q, match_d;

  always_comb begin
    color_d = color_q;
    count_d = count_q;
    match_d = match_q;
    if (capture_i) begin
      match_d = valid_i && (color_q == pix_i);
    end
    if (shift_i) begin
      color_d = next_color_i;
      count_d = next_count_i;
    end else if (write_i) begin
      color_d = wr_color_i;
      count_d = CountW'(1);
    end else if (inc_i && (count_q != '1)) begin
      count_d = count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q <= color_d;
    count_q <= count_d;
  end

  assign color_o = color_q;
  assign count_o = count_q;
  assign match_o = match_q;

endmodule

/* src/dch_datapath.sv */
// Datapath of the histogram: the row of table entries, fill and drop counters, dump index.
// Depends on dch_pkg and dch_lane.
module dch_datapath #(
  parameter int unsigned TableEntries = dch_pkg::TableEntriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dch_pkg::cmd_t                 cmd_i,
  input  logic [dch_pkg::ColorW-1:0]    pix_i,
  input  logic                          frame_end_i,
  output dch_pkg::status_t              status_o,
  output logic [dch_pkg::EntryNumW-1:0] entry_number_o,
  output logic [dch_pkg::ColorW-1:0]    color_o,
  output logic [dch_pkg::CountW-1:0]    occurrences_o,
  output logic [dch_pkg::CountW-1:0]    dropped_o
);
  import dch_pkg::*;

  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned UsedW = $clog2(TableEntries + 1);

  logic [ColorW-1:0] color [TableEntries];
  logic [CountW-1:0] count [TableEntries];
  logic [TableEntries-1:0] match;

  logic [ColorW-1:0] pix_q;
  logic              frame_end_q;
  logic [UsedW-1:0]  used_q, used_d;
  logic [CountW-1:0] dropped_q, dropped_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              any_match;
  logic              is_final;

  assign any_match = |match;
  assign is_final  = ((UsedW'(idx_q) + UsedW'(1)) == used_q);

  for (genvar i = 0; i < TableEntries; i++) begin : g_lane
    logic [ColorW-1:0] next_color;
    logic [CountW-1:0] next_count;
    if (i == TableEntries - 1) begin : g_tail
      assign next_color = color[i];
      assign next_count = count[i];
    end else begin : g_body
      assign next_color = color[i+1];
      assign next_count = count[i+1];
    end
    dch_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .valid_i     (UsedW'(i) < used_q),
      .capture_i   (cmd_i.capture),
      .inc_i       (cmd_i.update && match[i]),
      .write_i     (cmd_i.update && !any_match && (used_q == UsedW'(i))),
      .shift_i     (cmd_i.shift),
      .pix_i       (pix_i),
      .wr_color_i  (pix_q),
      .next_color_i(next_color),
      .next_count_i(next_count),
      .color_o     (color[i]),
      .count_o     (count[i]),
      .match_o     (match[i])
    );
  end

  always_comb begin
    used_d    = used_q;
    dropped_d = dropped_q;
    idx_d     = idx_q;
    if (cmd_i.update && !any_match) begin
      if (used_q != UsedW'(TableEntries)) begin
        used_d = used_q + UsedW'(1);
      end else if (dropped_q != '1) begin
        dropped_d = dropped_q + CountW'(1);
      end
    end
    if (cmd_i.shift) begin
      if (is_final) begin
        used_d    = '0;
        dropped_d = '0;
        idx_d     = '0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      dropped_q   <= '0;
      idx_q       <= '0;
      frame_end_q <= 1'b0;
    end else begin
      used_q    <= used_d;
      dropped_q <= dropped_d;
      idx_q     <= idx_d;
      if (cmd_i.capture) begin
        frame_end_q <= frame_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= pix_i;
    end
  end

  assign status_o.frame_end   = frame_end_q;
  assign status_o.final_entry = is_final;
  assign entry_number_o       = EntryNumW'(idx_q);
  assign color_o              = color[0];
  assign occurrences_o        = count[0];
  assign dropped_o            = dropped_q;

endmodule

/* src/dch_ctrl.sv */
// Controller of the histogram: sequences capture, write-back and the table dump.
// Depends on dch_pkg.
module dch_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  dch_pkg::status_t status_i,
  output dch_pkg::cmd_t    cmd_o
);
  import dch_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StUpdate,
    StDump
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = status_i.frame_end ? StDump : StIdle;
      end
      StDump: begin
        out_valid_o = 1'b1;
        cmd_o.shift = out_ready_i;
        if (out_ready_i && status_i.final_entry) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/distinct_color_histogram_unit.sv */
// Distinct color histogram: top level joining controller and datapath.
// Depends on dch_pkg, dch_ctrl and dch_datapath.
// A pixel is first compared against all entries in the capture state, then its count is written
// back in the write-back state, so no new pixel is accepted until that write-back is done.
// After a frame_end pixel the results start once its write-back state is done, one per cycle while
// the sink is ready; no pixel is accepted during the dump.
// Reset clears the fill count, drop counter and controller; table contents are not cleared.
module distinct_color_histogram_unit #(
  parameter int unsigned TableEntries = dch_pkg::TableEntriesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // red [7:0], green [15:8], blue [23:16], alpha [31:24]
  input  logic [dch_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         s_axis_tlast,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // entry_number [5:0], out_red [13:6], out_green [21:14], out_blue [29:22],
  // out_alpha [37:30], occurrences [53:38], dropped_pixels [69:54], zero [71:70]
  output logic [dch_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);
  import dch_pkg::*;

  cmd_t                 cmd;
  status_t              status;
  logic [EntryNumW-1:0] entry_number;
  logic [ColorW-1:0]    color;
  logic [CountW-1:0]    occurrences;
  logic [CountW-1:0]    dropped;

  dch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dch_datapath #(
    .TableEntries(TableEntries)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .pix_i         (s_axis_tdata),
    .frame_end_i   (s_axis_tlast),
    .status_o      (status),
    .entry_number_o(entry_number),
    .color_o       (color),
    .occurrences_o (occurrences),
    .dropped_o     (dropped)
  );

  assign m_axis_tdata = {2'b00, dropped, occurrences, color, entry_number};
  assign m_axis_tlast = status.final_entry;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted during dump");

  a_two_cycle_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("pixel accepted before write-back");

  a_dump_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("dump continued past final entry");

endmodule

/* test/distinct_color_histogram_unit_tb.sv */
// Self-checking testbench for distinct_color_histogram_unit: pixel frames in, dumped entries out.
// A scoreboard class tallies colors per frame and checks every dumped entry field by field.
// Depends on dch_pkg and the distinct_color_histogram_unit RTL.
module distinct_color_histogram_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableSize = dch_pkg::TableEntriesDefault;
  localparam int unsigned TotalItems = 460;
  localparam int unsigned DropItems = 16;
  localparam int unsigned IdlePercent = 37;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CycleLimit = 3_000_000;
  localparam int unsigned ReportLimit = 200;

  typedef struct {
    logic [5:0]  entry_number;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] occurrences;
    logic [15:0] dropped_pixels;
    logic        final_entry;
  } hist_entry_t;

  class color_tally;
    logic [31:0] colors[TableSize];
    logic [15:0] counts[TableSize];
    int unsigned used;
    logic [15:0] dropped;
    hist_entry_t expected_entries[$];
    int unsigned errors;

    function new();
      used = 0;
      dropped = '0;
      errors = 0;
    endfunction

    function void note_pixel(logic [31:0] rgba, logic frame_end);
      bit hit;
      hist_entry_t e;
      hit = 1'b0;
      for (int unsigned i = 0; i < used; i++) begin
        if (!hit && colors[i] == rgba) begin
          hit = 1'b1;
          if (counts[i] != 16'hFFFF) counts[i] = counts[i] + 16'd1;
        end
      end
      if (!hit) begin
        if (used < TableSize) begin
          colors[used] = rgba;
          counts[used] = 16'd1;
          used++;
        end else if (dropped != 16'hFFFF) begin
          dropped = dropped + 16'd1;
        end
      end
      if (frame_end) begin
        for (int unsigned i = 0; i < used; i++) begin
          e.entry_number = i[5:0];
          e.red = colors[i][7:0];
          e.green = colors[i][15:8];
          e.blue = colors[i][23:16];
          e.alpha = colors[i][31:24];
          e.occurrences = counts[i];
          e.dropped_pixels = dropped;
          e.final_entry = (i + 1 == used);
          expected_entries.push_back(e);
        end
        used = 0;
        dropped = '0;
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_entry(logic [dch_pkg::OutDataW-1:0] word, logic last);
      hist_entry_t e;
      if (expected_entries.size() == 0) begin
        errors++;
        if (errors <= ReportLimit)
          $display("%0t: unexpected result, expected none, actual %0h last %0b",
                   $time, word, last);
        return;
      end
      e = expected_entries.pop_front();
      compare_field("entry_number", 16'(e.entry_number), 16'(word[5:0]));
      compare_field("out_red", 16'(e.red), 16'(word[13:6]));
      compare_field("out_green", 16'(e.green), 16'(word[21:14]));
      compare_field("out_blue", 16'(e.blue), 16'(word[29:22]));
      compare_field("out_alpha", 16'(e.alpha), 16'(word[37:30]));
      compare_field("occurrences", e.occurrences, word[53:38]);
      compare_field("dropped_pixels", e.dropped_pixels, word[69:54]);
      compare_field("padding", 16'd0, 16'(word[71:70]));
      compare_field("final_entry", 16'(e.final_entry), 16'(last));
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [dch_pkg::InDataW-1:0]  s_axis_tdata;
  logic                         s_axis_tlast;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [dch_pkg::OutDataW-1:0] m_axis_tdata;
  logic                         m_axis_tlast;

  color_tally  sb = new();
  bit          no_idle = 1'b0;
  bit          pressure_armed = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  distinct_color_histogram_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // The rgba word is the tdata layout: red in the lowest byte, alpha in the highest.
  task automatic send_pixel(input logic [31:0] rgba, input logic last);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rgba;
    s_axis_tlast <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pixel(rgba, last);
    items_sent++;
  endtask

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_entry(m_axis_tdata, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (pressure_armed && m_axis_tvalid) begin
        pressure_armed = 1'b0;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  initial begin
    int unsigned k;
    int unsigned len;
    int unsigned kind;
    int unsigned pal_size;
    logic [31:0] base;
    logic [31:0] palette[8];

    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    send_pixel(32'h0000_0000, 1'b1);
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // Colors that differ only in alpha must land in separate entries.
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h0100_0000, 1'b0);
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'h0000_FF00, 1'b0);
    send_pixel(32'h00FF_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h0100_0000, 1'b1);
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'hAAAA_AAAA, 1'b0);
    send_pixel(32'h5555_5555, 1'b1);

    // Full table frame: fill every entry, repeat one color, then offer colors that are dropped.
    no_idle = 1'b1;
    for (k = 0; k < TableSize; k++) send_pixel(k * 32'h0101_0101, 1'b0);
    for (k = 0; k < 8; k++) send_pixel(32'h0000_0000, 1'b0);
    for (k = 0; k < DropItems; k++) send_pixel(32'hFF00_0000 | k, 1'b0);
    send_pixel(32'h0101_0101, 1'b1);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_entries.size() != 0) @(posedge clk_i);
    no_idle = 1'b0;

    pressure_armed = 1'b1;
    while (items_sent < TotalItems) begin
      kind = $urandom_range(99);
      if (kind < 12) begin
        len = $urandom_range(80, 60);
        for (k = 0; k < len; k++) send_pixel($urandom(), k == len - 1);
      end else if (kind < 24) begin
        base = $urandom();
        len = $urandom_range(12, 2);
        for (k = 0; k < len; k++)
          send_pixel(base ^ ($urandom_range(1) ? (32'h1 << $urandom_range(31)) : 32'h0),
                     k == len - 1);
      end else if (kind < 32) begin
        send_pixel($urandom(), 1'b1);
      end else begin
        pal_size = $urandom_range(8, 1);
        for (k = 0; k < pal_size; k++) palette[k] = $urandom();
        len = $urandom_range(16, 1);
        for (k = 0; k < len; k++)
          send_pixel(palette[$urandom_range(pal_size - 1)], k == len - 1);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_entries.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
